// File: sv/rcsmh_pkg.sv
// Package with the shared types, constants and the advertising channel table.
`timescale 1ns / 1ps
`default_nettype none

package rcsmh_pkg;

    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [6:0] NO_SIGNAL   = 7'd127;
    localparam logic [6:0] ADV_CH_A    = 7'd2;
    localparam logic [6:0] ADV_CH_B    = 7'd26;
    localparam logic [6:0] ADV_CH_C    = 7'd80;
    localparam logic [1:0] ADV_LAST    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LOWEST   = 3'd0;
    localparam logic [2:0] REG_HIGHEST  = 3'd1;
    localparam logic [2:0] REG_REPEATS  = 3'd2;
    localparam logic [2:0] REG_ADV_ONLY = 3'd3;
    localparam logic [2:0] REG_SEND_EN  = 3'd4;

    typedef struct packed {
        logic [6:0] lowest_channel;
        logic [6:0] highest_channel;
        logic [6:0] repeats_per_channel;
        logic       advertising_only;
        logic       send_enable;
    } cfg_t;

    typedef struct packed {
        logic [6:0] channel;
        logic [6:0] value;
        logic [6:0] next_channel;
    } frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

    typedef enum logic [1:0] {
        BYTE_START = 2'd0,
        BYTE_CHAN  = 2'd1,
        BYTE_VALUE = 2'd2
    } byte_sel_t;

    function automatic logic [6:0] adv_channel(input logic [1:0] idx);
        logic [6:0] ch;
        unique case (idx)
            2'd0:    ch = ADV_CH_A;
            2'd1:    ch = ADV_CH_B;
            2'd2:    ch = ADV_CH_C;
            default: ch = ADV_CH_A;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: sv/rcsmh_core.sv
// Minimum hold, repeat counter and channel stepping for each accepted sample.
`timescale 1ns / 1ps
`default_nettype none

module rcsmh_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [6:0]           rssi_sample,
    input  wire rcsmh_pkg::cfg_t      cfg,
    output rcsmh_pkg::frame_push_t    push_out
);
    import rcsmh_pkg::*;

    logic [6:0] current_channel_reg, current_channel_next;
    logic [6:0] repeat_count_reg, repeat_count_next;
    logic [6:0] held_minimum_reg, held_minimum_next;
    logic [1:0] adv_index_reg, adv_index_next;

    logic [6:0] needed;
    logic [6:0] min_value;
    logic [6:0] count_inc;
    logic       fire;
    logic [1:0] adv_step;
    logic [6:0] channel_step;

    always_comb
    begin
        needed    = (cfg.repeats_per_channel == 7'd0) ? 7'd1 : cfg.repeats_per_channel;
        min_value = (rssi_sample < held_minimum_reg) ? rssi_sample : held_minimum_reg;
        count_inc = repeat_count_reg + 7'd1;
        fire      = (count_inc >= needed);

        adv_step = (adv_index_reg >= ADV_LAST) ? 2'd0 : adv_index_reg + 2'd1;
        if (cfg.advertising_only)
        begin
            channel_step = adv_channel(adv_step);
        end
        else if (current_channel_reg >= cfg.highest_channel)
        begin
            channel_step = cfg.lowest_channel;
        end
        else
        begin
            channel_step = current_channel_reg + 7'd1;
        end

        current_channel_next = current_channel_reg;
        repeat_count_next    = repeat_count_reg;
        held_minimum_next    = held_minimum_reg;
        adv_index_next       = adv_index_reg;
        if (accept)
        begin
            if (fire)
            begin
                current_channel_next = channel_step;
                repeat_count_next    = 7'd0;
                held_minimum_next    = NO_SIGNAL;
                if (cfg.advertising_only)
                begin
                    adv_index_next = adv_step;
                end
            end
            else
            begin
                repeat_count_next = count_inc;
                held_minimum_next = min_value;
            end
        end

        push_out.push               = accept && fire && cfg.send_enable;
        push_out.frame.channel      = current_channel_reg;
        push_out.frame.value        = min_value;
        push_out.frame.next_channel = channel_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_channel_reg <= 7'd0;
            repeat_count_reg    <= 7'd0;
            held_minimum_reg    <= NO_SIGNAL;
            adv_index_reg       <= 2'd0;
        end
        else
        begin
            current_channel_reg <= current_channel_next;
            repeat_count_reg    <= repeat_count_next;
            held_minimum_reg    <= held_minimum_next;
            adv_index_reg       <= adv_index_next;
        end
    end

`ifndef ASSERT_OFF
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fire) |=> (repeat_count_reg == 7'd0 && held_minimum_reg == NO_SIGNAL))
        else $error("hold not cleared after a channel was reported");
    a_adv_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fire && cfg.advertising_only) |=>
        (current_channel_reg == ADV_CH_A || current_channel_reg == ADV_CH_B ||
         current_channel_reg == ADV_CH_C))
        else $error("advertising step left the advertising channels");
`endif

endmodule

`default_nettype wire

// File: sv/rcsmh_framer.sv
// Two-frame queue that sends each frame out as three words.
`timescale 1ns / 1ps
`default_nettype none

module rcsmh_framer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rcsmh_pkg::frame_push_t push_in,
    output logic                       full,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 frame_byte,
    output logic                       frame_end,
    output logic [6:0]                 next_channel
);
    import rcsmh_pkg::*;

    frame_t    slot_reg [2];
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    byte_sel_t sel_reg, sel_next;
    logic      out_take;
    logic      pop;
    frame_t    head;

    always_comb
    begin
        head      = slot_reg[rd_ptr_reg];
        full      = (count_reg == 2'd2);
        out_valid = (count_reg != 2'd0);
        out_take  = out_valid && !out_stall;
        pop       = out_take && (sel_reg == BYTE_VALUE);

        unique case (sel_reg)
            BYTE_START: frame_byte = FRAME_START;
            BYTE_CHAN:  frame_byte = {1'b0, head.channel};
            BYTE_VALUE: frame_byte = {1'b0, head.value};
            default:    frame_byte = FRAME_START;
        endcase
        frame_end    = (sel_reg == BYTE_VALUE);
        next_channel = head.next_channel;

        sel_next = sel_reg;
        if (out_take)
        begin
            unique case (sel_reg)
                BYTE_START: sel_next = BYTE_CHAN;
                BYTE_CHAN:  sel_next = BYTE_VALUE;
                BYTE_VALUE: sel_next = BYTE_START;
                default:    sel_next = BYTE_START;
            endcase
        end

        wr_ptr_next = push_in.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_in.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            slot_reg[wr_ptr_reg] <= push_in.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sel_reg    <= BYTE_START;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_in.push |-> (count_reg != 2'd2))
        else $error("frame pushed into a full queue");
    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (sel_reg == BYTE_START))
        else $error("next frame does not begin with its start word");
`endif

endmodule

`default_nettype wire

// File: sv/rssi_channel_sweep_min_hold.sv
// Top level of the RSSI channel sweep with minimum hold and its register port.
`timescale 1ns / 1ps
`default_nettype none

// A sample that completes a channel while sending is enabled and the queue is empty has
// its first frame word valid from the next cycle; the three words follow one per cycle
// while out_stall is low. Throughput: one sample per cycle; each frame holds the output
// for three words, and the sample input stalls only while two frames wait in the queue.
// Reset (rst_n, asynchronous, active low) loads the register defaults, channel 0, an
// empty hold of 127, a zero repeat count and an empty frame queue.
module rssi_channel_sweep_min_hold (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [4:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [6:0] rssi_sample,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      frame_byte,
    output logic            frame_end,
    output logic [6:0]      next_channel
);
    import rcsmh_pkg::*;

    // Configuration registers; a write lands in the access phase of the APB cycle.
    cfg_t        cfg_reg, cfg_next;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic        in_accept;
    logic        queue_full;
    frame_push_t push;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_LOWEST:   cfg_next.lowest_channel      = pwdata[6:0];
                REG_HIGHEST:  cfg_next.highest_channel     = pwdata[6:0];
                REG_REPEATS:  cfg_next.repeats_per_channel = pwdata[6:0];
                REG_ADV_ONLY: cfg_next.advertising_only    = pwdata[0];
                REG_SEND_EN:  cfg_next.send_enable         = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end

        // Read-back of the register at the addressed word.
        unique case (reg_index)
            REG_LOWEST:   prdata = {25'd0, cfg_reg.lowest_channel};
            REG_HIGHEST:  prdata = {25'd0, cfg_reg.highest_channel};
            REG_REPEATS:  prdata = {25'd0, cfg_reg.repeats_per_channel};
            REG_ADV_ONLY: prdata = {31'd0, cfg_reg.advertising_only};
            REG_SEND_EN:  prdata = {31'd0, cfg_reg.send_enable};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lowest_channel      <= 7'd0;
            cfg_reg.highest_channel     <= 7'd80;
            cfg_reg.repeats_per_channel <= 7'd1;
            cfg_reg.advertising_only    <= 1'b0;
            cfg_reg.send_enable         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A sample is refused only while the frame queue holds two frames, since any
    // accepted sample may complete a channel and need a slot.
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !in_stall;

    rcsmh_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .rssi_sample (rssi_sample),
        .cfg         (cfg_reg),
        .push_out    (push)
    );

    rcsmh_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_in      (push),
        .full         (queue_full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .frame_end    (frame_end),
        .next_channel (next_channel)
    );

endmodule

`default_nettype wire
